FILE: hdl/assert_macros.svh
// assertion helpers used by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define HDFE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked through reset as well
`define HDFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/hdfe_pkg.sv
package hdfe_pkg;

  // parameter defaults
  localparam int MAX_FIELDS_DEF  = 32;
  localparam int MAX_USAGES_DEF  = 32;
  localparam int STACK_DEPTH_DEF = 4;

  // number of report ids
  localparam int REPORT_IDS = 256;

  // long item prefix
  localparam logic [7:0] LONG_PREFIX = 8'hFE;

  // item types
  localparam logic [1:0] ITYPE_MAIN   = 2'd0;
  localparam logic [1:0] ITYPE_GLOBAL = 2'd1;
  localparam logic [1:0] ITYPE_LOCAL  = 2'd2;

  // main item tags
  localparam logic [3:0] TAG_INPUT    = 4'd8;
  localparam logic [3:0] TAG_COLL     = 4'd10;
  localparam logic [3:0] TAG_END_COLL = 4'd12;

  // global item tags
  localparam logic [3:0] G_PAGE   = 4'd0;
  localparam logic [3:0] G_LMIN   = 4'd1;
  localparam logic [3:0] G_LMAX   = 4'd2;
  localparam logic [3:0] G_RSIZE  = 4'd7;
  localparam logic [3:0] G_RID    = 4'd8;
  localparam logic [3:0] G_RCOUNT = 4'd9;
  localparam logic [3:0] G_PUSH   = 4'd10;
  localparam logic [3:0] G_POP    = 4'd11;

  // local item tags
  localparam logic [3:0] L_USAGE = 4'd0;
  localparam logic [3:0] L_UMIN  = 4'd1;
  localparam logic [3:0] L_UMAX  = 4'd2;

  // generic desktop page and gamepad-like usages
  localparam logic [15:0] PAGE_GDESK  = 16'h0001;
  localparam logic [15:0] USAGE_JOY   = 16'h0004;
  localparam logic [15:0] USAGE_PAD   = 16'h0005;
  localparam logic [15:0] USAGE_MULTI = 16'h0008;

  // widest field in bits
  localparam logic [7:0] MAX_BIT_SIZE = 8'd32;

  // record kinds and verdict codes
  localparam logic REC_FIELD   = 1'b0;
  localparam logic REC_VERDICT = 1'b1;
  localparam logic [1:0] VER_OK        = 2'd0;
  localparam logic [1:0] VER_NO_PAD    = 2'd1;
  localparam logic [1:0] VER_NO_FIELDS = 2'd2;
  localparam logic [1:0] VER_TRUNC     = 2'd3;

  // register map
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_FORCE_ADDR = 3'd0;

  // byte assembly phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SHORT,
    PH_LHDR,
    PH_LDATA
  } phase_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_IN_START,
    S_USE_RD,
    S_EMIT,
    S_OFF_WR,
    S_COLL,
    S_VERDICT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic in_start;
    logic use_rd;
    logic emit_step;
    logic emit_load;
    logic off_wr;
    logic coll;
    logic verdict;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_done;
    logic last_in;
    logic last_flag;
    logic is_input;
    logic is_coll;
    logic do_loop;
    logic rec_ok;
    logic i_last;
    logic out_free;
  } ctrl_sts_t;

  // data bytes of a short item from its size code
  function automatic logic [2:0] data_size(input logic [1:0] sc);
    return (sc == 2'd3) ? 3'd4 : {1'b0, sc};
  endfunction

endpackage

FILE: hdl/hdfe_if.sv
// descriptor byte channel
interface hdfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       end_of_descriptor;

  modport source(output valid, desc_byte, end_of_descriptor, input ready);
  modport sink(input valid, desc_byte, end_of_descriptor, output ready);
endinterface

// result record channel
interface hdfe_out_if;
  logic               valid;
  logic               ready;
  logic               record_kind;
  logic [7:0]         report_id;
  logic [15:0]        bit_offset;
  logic [5:0]         bit_size;
  logic [15:0]        usage_page;
  logic [15:0]        usage_id;
  logic signed [31:0] logical_min;
  logic signed [31:0] logical_max;
  logic               uses_report_ids;
  logic [1:0]         verdict;
  logic               last_of_run;

  modport source(output valid, record_kind, report_id, bit_offset, bit_size, usage_page,
                 usage_id, logical_min, logical_max, uses_report_ids, verdict, last_of_run,
                 input ready);
  modport sink(input valid, record_kind, report_id, bit_offset, bit_size, usage_page,
               usage_id, logical_min, logical_max, uses_report_ids, verdict, last_of_run,
               output ready);
endinterface

FILE: hdl/hdfe_ram.sv
module hdfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/hdfe_ctrl.sv
`include "assert_macros.svh"

module hdfe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hdfe_pkg::ctrl_sts_t sts,
  output hdfe_pkg::ctrl_cmd_t cmd
);
  import hdfe_pkg::*;

  ctrl_state_t state, state_next, fin_state;

  assign fin_state = sts.last_flag ? S_VERDICT : S_IDLE;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.item_done) begin
            state_next = S_EXEC;
          end else if (sts.last_in) begin
            state_next = S_VERDICT;
          end
        end
      end
      S_EXEC: begin
        if (sts.is_input) begin
          state_next = S_IN_START;
        end else if (sts.is_coll) begin
          state_next = S_COLL;
        end else begin
          state_next = fin_state;
        end
      end
      S_IN_START: state_next = sts.do_loop ? S_USE_RD : S_OFF_WR;
      S_USE_RD:   state_next = S_EMIT;
      S_EMIT: begin
        if (!sts.rec_ok || sts.out_free) begin
          state_next = sts.i_last ? S_OFF_WR : S_USE_RD;
        end
      end
      S_OFF_WR:  state_next = fin_state;
      S_COLL:    state_next = fin_state;
      S_VERDICT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_EXEC:     cmd.exec = 1'b1;
      S_IN_START: cmd.in_start = 1'b1;
      S_USE_RD:   cmd.use_rd = 1'b1;
      S_EMIT: begin
        if (!sts.rec_ok || sts.out_free) begin
          cmd.emit_step = 1'b1;
          cmd.emit_load = sts.rec_ok;
        end
      end
      S_OFF_WR: cmd.off_wr = 1'b1;
      S_COLL:   cmd.coll = 1'b1;
      S_VERDICT: cmd.verdict = sts.out_free;
      default: cmd = '0;
    endcase
  end

  // checks
  `HDFE_ASSERT(a_load_free, clk, rst, (cmd.emit_load || cmd.verdict) |-> sts.out_free, "record loaded over a waiting record")
  `HDFE_ASSERT(a_verdict_idle, clk, rst, cmd.verdict |=> in_ready, "no return to idle after verdict")
  `HDFE_ASSERT(a_exec_after_accept, clk, rst, (state == S_EXEC) |-> $past(cmd.accept), "item executed without a byte")

endmodule

FILE: hdl/hdfe_dp.sv
module hdfe_dp #(
  parameter int MAX_FIELDS  = hdfe_pkg::MAX_FIELDS_DEF,
  parameter int MAX_USAGES  = hdfe_pkg::MAX_USAGES_DEF,
  parameter int STACK_DEPTH = hdfe_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          desc_byte,
  input  logic                end_of_descriptor,
  input  logic                force_gamepad,
  input  hdfe_pkg::ctrl_cmd_t cmd,
  output hdfe_pkg::ctrl_sts_t sts,
  hdfe_out_if.source          rec_out
);
  import hdfe_pkg::*;

  localparam int FEW = $clog2(MAX_FIELDS + 1);
  localparam int UFW = $clog2(MAX_USAGES + 1);
  localparam int UAW = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;
  localparam int SLW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int RAW = $clog2(REPORT_IDS);

  // byte assembly
  phase_t      phase, phase_n;
  logic [7:0]  prefix, prefix_n;
  logic [31:0] accum, accum_n;
  logic [8:0]  pending, pending_n;
  logic        done_now;
  logic [7:0]  run_pfx_n;
  logic [31:0] run_val_n;
  logic [1:0]  sidx;

  // item being executed
  logic [7:0]  run_pfx;
  logic [31:0] run_val;
  logic        last_flag;

  // global state
  logic [15:0] page_reg;
  logic [31:0] min_reg, max_reg;
  logic [7:0]  size_reg, count_reg, id_reg;
  logic [63:0] stack_lim [STACK_DEPTH];
  logic [39:0] stack_sz  [STACK_DEPTH];
  logic [SLW-1:0] stack_level;

  // local state
  logic [UFW-1:0] usage_fill;
  logic [15:0]    range_low, range_high;
  logic [1:0]     range_flags;

  // collection and field state
  logic [7:0]     nest_depth, pad_depth;
  logic [FEW-1:0] fields_emitted;
  logic           pad_found, ids_seen;
  logic [15:0]    top_page, top_usage;
  logic [REPORT_IDS-1:0] off_valid;

  // input item walk
  logic [15:0] off_cur;
  logic [7:0]  i_cnt;
  logic        emit_mode;

  // ram ports
  logic           use_we;
  logic [UAW-1:0] use_waddr, use_raddr;
  logic [15:0]    use_q, off_q;

  // decode
  logic [1:0]  itype;
  logic [3:0]  itag;
  logic [2:0]  dsize;
  logic [31:0] sval;
  logic [15:0] off_base;

  // usage pick
  logic [7:0]  pick_i;
  logic        in_list;
  logic [16:0] rsum;
  logic [15:0] pick_val;
  logic        pad_usage;

  logic        out_free;
  logic        rec_last;

  assign itype = run_pfx[3:2];
  assign itag  = run_pfx[7:4];
  assign dsize = data_size(run_pfx[1:0]);

  // sign extension of one and two byte data
  always_comb begin
    sval = run_val;
    if (dsize == 3'd1 && run_val[7]) begin
      sval = run_val | 32'hFFFF_FF00;
    end else if (dsize == 3'd2 && run_val[15]) begin
      sval = run_val | 32'hFFFF_0000;
    end
  end

  // next assembly state for the byte on the channel
  always_comb begin
    phase_n   = phase;
    prefix_n  = prefix;
    accum_n   = accum;
    pending_n = pending;
    done_now  = 1'b0;
    run_pfx_n = prefix;
    run_val_n = 32'd0;
    sidx      = 2'(data_size(prefix[1:0]) - pending[2:0]);
    case (phase)
      PH_IDLE: begin
        if (desc_byte == LONG_PREFIX) begin
          phase_n   = PH_LHDR;
          pending_n = 9'd2;
        end else begin
          prefix_n  = desc_byte;
          accum_n   = 32'd0;
          run_pfx_n = desc_byte;
          if (data_size(desc_byte[1:0]) == 3'd0) begin
            done_now = 1'b1;
          end else begin
            phase_n   = PH_SHORT;
            pending_n = 9'(data_size(desc_byte[1:0]));
          end
        end
      end
      PH_SHORT: begin
        accum_n   = accum | (32'(desc_byte) << {sidx, 3'b000});
        pending_n = pending - 9'd1;
        if (pending == 9'd1) begin
          phase_n   = PH_IDLE;
          done_now  = 1'b1;
          run_val_n = accum_n;
        end
      end
      PH_LHDR: begin
        if (pending == 9'd2) begin
          accum_n   = 32'(desc_byte);
          pending_n = 9'd1;
        end else if (accum == 32'd0) begin
          phase_n   = PH_IDLE;
          pending_n = 9'd0;
        end else begin
          phase_n   = PH_LDATA;
          pending_n = 9'(accum[7:0]);
        end
      end
      PH_LDATA: begin
        pending_n = pending - 9'd1;
        if (pending == 9'd1) begin
          phase_n = PH_IDLE;
        end
      end
      default: phase_n = PH_IDLE;
    endcase
  end

  // usage chosen for a report count entry or a collection
  assign pick_i  = cmd.coll ? 8'd0 : i_cnt;
  assign in_list = 9'(pick_i) < 9'(usage_fill);
  assign rsum    = 17'(range_low) + 17'(pick_i);
  always_comb begin
    if (in_list) begin
      pick_val = use_q;
    end else if (range_flags == 2'b11 && rsum <= 17'(range_high)) begin
      pick_val = rsum[15:0];
    end else if (usage_fill != '0) begin
      pick_val = use_q;
    end else begin
      pick_val = 16'd0;
    end
  end
  assign pad_usage = page_reg == PAGE_GDESK &&
                     (pick_val == USAGE_JOY || pick_val == USAGE_PAD ||
                      pick_val == USAGE_MULTI);

  // usage list ram, read address held while a record waits
  assign use_we    = cmd.exec && itype == ITYPE_LOCAL && itag == L_USAGE &&
                     usage_fill < UFW'(MAX_USAGES);
  assign use_waddr = UAW'(usage_fill);
  assign use_raddr = cmd.exec ? '0 :
                     (9'(i_cnt) < 9'(usage_fill)) ? UAW'(i_cnt) :
                     UAW'(usage_fill - UFW'(1));

  hdfe_ram #(.WIDTH(16), .DEPTH(MAX_USAGES)) u_usage_ram (
    .clk   (clk),
    .we    (use_we),
    .waddr (use_waddr),
    .wdata (run_val[15:0]),
    .raddr (use_raddr),
    .rdata (use_q)
  );

  // bit offset per report id
  hdfe_ram #(.WIDTH(16), .DEPTH(REPORT_IDS)) u_offset_ram (
    .clk   (clk),
    .we    (cmd.off_wr),
    .waddr (RAW'(id_reg)),
    .wdata (off_cur),
    .raddr (RAW'(id_reg)),
    .rdata (off_q)
  );

  assign off_base = off_valid[id_reg] ? off_q : 16'd0;

  // record conditions
  assign out_free = !rec_out.valid || rec_out.ready;
  assign rec_last = (i_cnt == 8'(count_reg - 8'd1)) ||
                    (FEW'(fields_emitted + FEW'(1)) == FEW'(MAX_FIELDS));

  always_comb begin
    sts           = '0;
    sts.item_done = done_now;
    sts.last_in   = end_of_descriptor;
    sts.last_flag = last_flag;
    sts.is_input  = itype == ITYPE_MAIN && itag == TAG_INPUT;
    sts.is_coll   = itype == ITYPE_MAIN && itag == TAG_COLL;
    sts.do_loop   = pad_depth != 8'd0 && !run_val[0] && run_val[1] && count_reg != 8'd0;
    sts.rec_ok    = emit_mode && fields_emitted < FEW'(MAX_FIELDS) &&
                    size_reg != 8'd0 && size_reg <= MAX_BIT_SIZE;
    sts.i_last    = i_cnt == 8'(count_reg - 8'd1);
    sts.out_free  = out_free;
  end

  // assembly registers
  always_ff @(posedge clk) begin
    if (rst || cmd.verdict) begin
      phase     <= PH_IDLE;
      prefix    <= 8'd0;
      accum     <= 32'd0;
      pending   <= 9'd0;
    end else if (cmd.accept) begin
      phase     <= phase_n;
      prefix    <= prefix_n;
      accum     <= accum_n;
      pending   <= pending_n;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (rst) begin
      last_flag <= 1'b0;
    end else if (cmd.accept) begin
      last_flag <= end_of_descriptor;
    end
    if (cmd.accept && done_now) begin
      run_pfx <= run_pfx_n;
      run_val <= run_val_n;
    end
  end

  // stack entries
  always_ff @(posedge clk) begin
    if (cmd.exec && itype == ITYPE_GLOBAL && itag == G_PUSH &&
        stack_level < SLW'(STACK_DEPTH)) begin
      stack_lim[stack_level[SAW-1:0]] <= {max_reg, min_reg};
      stack_sz[stack_level[SAW-1:0]]  <= {id_reg, count_reg, size_reg, page_reg};
    end
  end

  // item execution state
  always_ff @(posedge clk) begin
    if (rst || cmd.verdict) begin
      page_reg       <= 16'd0;
      min_reg        <= 32'd0;
      max_reg        <= 32'd0;
      size_reg       <= 8'd0;
      count_reg      <= 8'd0;
      id_reg         <= 8'd0;
      stack_level    <= '0;
      usage_fill     <= '0;
      range_low      <= 16'd0;
      range_high     <= 16'd0;
      range_flags    <= 2'b00;
      nest_depth     <= 8'd0;
      pad_depth      <= 8'd0;
      fields_emitted <= '0;
      pad_found      <= 1'b0;
      top_page       <= 16'd0;
      top_usage      <= 16'd0;
      ids_seen       <= 1'b0;
      off_valid      <= '0;
      emit_mode      <= 1'b0;
    end else begin
      // global and local items, and main items other than input and collection
      if (cmd.exec) begin
        case (itype)
          ITYPE_MAIN: begin
            if (itag != TAG_INPUT && itag != TAG_COLL) begin
              usage_fill  <= '0;
              range_low   <= 16'd0;
              range_high  <= 16'd0;
              range_flags <= 2'b00;
            end
            if (itag == TAG_END_COLL) begin
              if (nest_depth == pad_depth) begin
                pad_depth <= 8'd0;
              end
              if (nest_depth != 8'd0) begin
                nest_depth <= nest_depth - 8'd1;
              end
            end
          end
          ITYPE_GLOBAL: begin
            case (itag)
              G_PAGE:   page_reg <= run_val[15:0];
              G_LMIN:   min_reg <= sval;
              G_LMAX:   max_reg <= min_reg[31] ? sval : run_val;
              G_RSIZE:  size_reg <= run_val[7:0];
              G_RID:    id_reg <= run_val[7:0];
              G_RCOUNT: count_reg <= run_val[7:0];
              G_PUSH: begin
                if (stack_level < SLW'(STACK_DEPTH)) begin
                  stack_level <= stack_level + SLW'(1);
                end
              end
              G_POP: begin
                if (stack_level != '0) begin
                  stack_level <= stack_level - SLW'(1);
                  min_reg   <= stack_lim[SAW'(stack_level - SLW'(1))][31:0];
                  max_reg   <= stack_lim[SAW'(stack_level - SLW'(1))][63:32];
                  page_reg  <= stack_sz[SAW'(stack_level - SLW'(1))][15:0];
                  size_reg  <= stack_sz[SAW'(stack_level - SLW'(1))][23:16];
                  count_reg <= stack_sz[SAW'(stack_level - SLW'(1))][31:24];
                  id_reg    <= stack_sz[SAW'(stack_level - SLW'(1))][39:32];
                end
              end
              default: ;
            endcase
          end
          ITYPE_LOCAL: begin
            case (itag)
              L_USAGE: begin
                if (usage_fill < UFW'(MAX_USAGES)) begin
                  usage_fill <= usage_fill + UFW'(1);
                end
              end
              L_UMIN: begin
                range_flags[0] <= 1'b1;
                range_low      <= run_val[15:0];
              end
              L_UMAX: begin
                range_flags[1] <= 1'b1;
                range_high     <= run_val[15:0];
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end

      // input item: set emit mode from the walk condition
      if (cmd.in_start) begin
        emit_mode <= sts.do_loop;
      end

      // input item: one report count entry
      if (cmd.emit_step && sts.rec_ok) begin
        fields_emitted <= fields_emitted + FEW'(1);
        if (id_reg != 8'd0) begin
          ids_seen <= 1'b1;
        end
      end

      // input item: store offset, drop locals
      if (cmd.off_wr) begin
        off_valid[id_reg] <= 1'b1;
        emit_mode         <= 1'b0;
        usage_fill        <= '0;
        range_low         <= 16'd0;
        range_high        <= 16'd0;
        range_flags       <= 2'b00;
      end

      // collection
      if (cmd.coll) begin
        if (nest_depth == 8'd0 && (pad_usage || force_gamepad)) begin
          pad_found <= 1'b1;
          top_page  <= (force_gamepad && page_reg == 16'd0) ? PAGE_GDESK : page_reg;
          top_usage <= (force_gamepad && pick_val == 16'd0) ? USAGE_PAD : pick_val;
          pad_depth <= nest_depth + 8'd1;
        end
        nest_depth  <= nest_depth + 8'd1;
        usage_fill  <= '0;
        range_low   <= 16'd0;
        range_high  <= 16'd0;
        range_flags <= 2'b00;
      end
    end
  end

  // offset walk
  always_ff @(posedge clk) begin
    if (cmd.in_start) begin
      i_cnt   <= 8'd0;
      off_cur <= sts.do_loop ? off_base :
                 off_base + 16'(16'(size_reg) * 16'(count_reg));
    end else if (cmd.emit_step) begin
      i_cnt   <= i_cnt + 8'd1;
      off_cur <= off_cur + 16'(size_reg);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_out.valid <= 1'b0;
    end else if (cmd.emit_load || cmd.verdict) begin
      rec_out.valid <= 1'b1;
    end else if (rec_out.ready) begin
      rec_out.valid <= 1'b0;
    end
    if (cmd.emit_load) begin
      rec_out.record_kind     <= REC_FIELD;
      rec_out.report_id       <= id_reg;
      rec_out.bit_offset      <= off_cur;
      rec_out.bit_size        <= size_reg[5:0];
      rec_out.usage_page      <= page_reg;
      rec_out.usage_id        <= pick_val;
      rec_out.logical_min     <= min_reg;
      rec_out.logical_max     <= max_reg;
      rec_out.uses_report_ids <= 1'b0;
      rec_out.verdict         <= VER_OK;
      rec_out.last_of_run     <= rec_last && !last_flag;
    end else if (cmd.verdict) begin
      rec_out.record_kind     <= REC_VERDICT;
      rec_out.report_id       <= 8'd0;
      rec_out.bit_offset      <= 16'd0;
      rec_out.bit_size        <= 6'd0;
      rec_out.usage_page      <= top_page;
      rec_out.usage_id        <= top_usage;
      rec_out.logical_min     <= 32'sd0;
      rec_out.logical_max     <= 32'sd0;
      rec_out.uses_report_ids <= ids_seen;
      rec_out.verdict         <= (phase != PH_IDLE) ? VER_TRUNC :
                                 !pad_found ? VER_NO_PAD :
                                 (fields_emitted == '0) ? VER_NO_FIELDS : VER_OK;
      rec_out.last_of_run     <= 1'b1;
    end
  end

endmodule

FILE: hdl/hid_descriptor_field_extractor.sv
// Parses a HID report descriptor fed one byte per request and sends out one
// field record for each report count entry of every variable, non-constant
// Input item inside a top-level gamepad, joystick or multi-axis collection
// (report size 1 to 32 bits, at most MAX_FIELDS records), then one verdict
// record on the byte flagged end_of_descriptor, after which all parse state
// returns to reset. A byte that completes an item is executed before the
// next byte is taken; a collection adds a collection step, and an Input item
// adds a start step and an offset store, with a usage list read and then a
// record for each report count entry walked inside a gamepad collection; the
// verdict has a step of its own. A record that waits on the output holds the
// walk or the verdict until it is taken. The per-id bit offsets live in a
// 256-entry memory with one valid flag per id, so reset and the end of each
// descriptor clear them at once with no clearing pass. force_gamepad sits
// at byte address 0 of the register port and is kept across descriptors.
module hid_descriptor_field_extractor #(
  parameter int MAX_FIELDS  = hdfe_pkg::MAX_FIELDS_DEF,
  parameter int MAX_USAGES  = hdfe_pkg::MAX_USAGES_DEF,
  parameter int STACK_DEPTH = hdfe_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  hdfe_in_if.sink                      desc_in,
  hdfe_out_if.source                   rec_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hdfe_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import hdfe_pkg::*;

  logic       force_gamepad;
  logic       in_ready;
  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_FORCE_ADDR) ? {31'd0, force_gamepad} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_gamepad <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_FORCE_ADDR) begin
      force_gamepad <= pwdata[0];
    end
  end

  assign desc_in.ready = in_ready;

  // sequencer
  hdfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (desc_in.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // parse state and record output
  hdfe_dp #(
    .MAX_FIELDS  (MAX_FIELDS),
    .MAX_USAGES  (MAX_USAGES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .desc_byte         (desc_in.desc_byte),
    .end_of_descriptor (desc_in.end_of_descriptor),
    .force_gamepad     (force_gamepad),
    .cmd               (cmd),
    .sts               (sts),
    .rec_out           (rec_out)
  );

endmodule

FILE: bench/hdfe_record_checker.sv
`timescale 1ns / 100ps

module hdfe_record_checker (
  input  logic                         clk,
  input  logic                         rst,
  hdfe_in_if                           din,
  hdfe_out_if                          dout,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [hdfe_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output int                           errors,
  output int                           outstanding
);
  import hdfe_pkg::*;

  localparam int FIELD_LIMIT = 32;
  localparam int USAGE_LIMIT = 32;
  localparam int STACK_LIMIT = 4;

  typedef struct packed {
    logic        kind;
    logic [7:0]  id;
    logic [15:0] off;
    logic [5:0]  bsize;
    logic [15:0] page;
    logic [15:0] usage;
    logic [31:0] lmin;
    logic [31:0] lmax;
    logic        ids;
    logic [1:0]  ver;
    logic        last;
  } field_rec_t;

  field_rec_t expected_recs[$];

  // parser mirror
  logic        force_pad;
  phase_t      phase;
  logic [7:0]  prefix;
  logic [31:0] accum;
  int          pend;
  logic [15:0] page_r;
  logic [31:0] min_r, max_r;
  logic [7:0]  size_r, count_r, id_r;
  logic [63:0] stk_lim [STACK_LIMIT];
  logic [39:0] stk_sz [STACK_LIMIT];
  int          lvl;
  logic [15:0] usages [USAGE_LIMIT];
  int          ufill;
  logic [15:0] rlo, rhi;
  logic [1:0]  rflags;
  logic [15:0] offsets [256];
  logic [7:0]  nest, pad_nest;
  int          nemit;
  logic        pad_seen;
  logic [15:0] top_pg, top_us;
  logic        ids_used;

  function automatic void clear_parser();
    phase = PH_IDLE; prefix = 0; accum = 0; pend = 0;
    page_r = 0; min_r = 0; max_r = 0; size_r = 0; count_r = 0; id_r = 0;
    lvl = 0; ufill = 0; rlo = 0; rhi = 0; rflags = 0;
    for (int i = 0; i < 256; i++) offsets[i] = 0;
    nest = 0; pad_nest = 0; nemit = 0; pad_seen = 0;
    top_pg = 0; top_us = 0; ids_used = 0;
  endfunction

  function automatic logic [15:0] usage_at(int i);
    logic [31:0] c;
    if (i < ufill) return usages[i];
    if (rflags == 2'b11) begin
      c = {16'b0, rlo} + i;
      if (c <= {16'b0, rhi}) return c[15:0];
    end
    if (ufill != 0) return usages[ufill-1];
    return 16'h0;
  endfunction

  function automatic void add_rec(logic kind, logic [7:0] id, logic [15:0] off,
                                  logic [7:0] bsize, logic [15:0] page, logic [15:0] usage,
                                  logic [31:0] lmin, logic [31:0] lmax, logic ids,
                                  logic [1:0] ver);
    field_rec_t r;
    r.kind = kind; r.id = id; r.off = off; r.bsize = bsize[5:0]; r.page = page;
    r.usage = usage; r.lmin = lmin; r.lmax = lmax; r.ids = ids; r.ver = ver;
    r.last = 1'b0;
    expected_recs.push_back(r);
  endfunction

  // execute one complete short item
  function automatic void run_short_item(logic [7:0] pfx, logic [31:0] val);
    logic [1:0]  itype;
    logic [3:0]  tag;
    logic [31:0] sval;
    logic [15:0] off, u;
    logic [7:0]  nd;
    logic        pad;
    itype = pfx[3:2];
    tag = pfx[7:4];
    sval = val;
    if (pfx[1:0] == 2'd1 && val[7]) sval = val | 32'hFFFFFF00;
    if (pfx[1:0] == 2'd2 && val[15]) sval = val | 32'hFFFF0000;
    if (itype == ITYPE_MAIN) begin
      if (tag == TAG_INPUT) begin
        off = offsets[id_r];
        if (pad_nest != 0 && !val[0] && val[1]) begin
          for (int i = 0; i < count_r; i++) begin
            if (nemit < FIELD_LIMIT && size_r != 0 && size_r <= MAX_BIT_SIZE) begin
              add_rec(REC_FIELD, id_r, off, size_r, page_r, usage_at(i), min_r, max_r,
                      1'b0, VER_OK);
              nemit++;
              if (id_r != 0) ids_used = 1'b1;
            end
            off = off + size_r;
          end
        end else begin
          off = off + 16'(16'(size_r) * 16'(count_r));
        end
        offsets[id_r] = off;
      end else if (tag == TAG_COLL) begin
        u = usage_at(0);
        nd = nest + 8'd1;
        pad = page_r == PAGE_GDESK &&
              (u == USAGE_JOY || u == USAGE_PAD || u == USAGE_MULTI);
        if (nest == 0 && (pad || force_pad)) begin
          pad_seen = 1'b1;
          top_pg = (force_pad && page_r == 0) ? PAGE_GDESK : page_r;
          top_us = (force_pad && u == 0) ? USAGE_PAD : u;
          pad_nest = nd;
        end
        nest = nd;
      end else if (tag == TAG_END_COLL) begin
        if (nest == pad_nest) pad_nest = 0;
        if (nest > 0) nest = nest - 8'd1;
      end
      ufill = 0; rlo = 0; rhi = 0; rflags = 0;
    end else if (itype == ITYPE_GLOBAL) begin
      case (tag)
        G_PAGE:   page_r = val[15:0];
        G_LMIN:   min_r = sval;
        G_LMAX:   max_r = min_r[31] ? sval : val;
        G_RSIZE:  size_r = val[7:0];
        G_RID:    id_r = val[7:0];
        G_RCOUNT: count_r = val[7:0];
        G_PUSH: begin
          if (lvl < STACK_LIMIT) begin
            stk_lim[lvl] = {max_r, min_r};
            stk_sz[lvl] = {id_r, count_r, size_r, page_r};
            lvl++;
          end
        end
        G_POP: begin
          if (lvl > 0) begin
            lvl--;
            {max_r, min_r} = stk_lim[lvl];
            {id_r, count_r, size_r, page_r} = stk_sz[lvl];
          end
        end
        default: ;
      endcase
    end else if (itype == ITYPE_LOCAL) begin
      if (tag == L_USAGE) begin
        if (ufill < USAGE_LIMIT) begin
          usages[ufill] = val[15:0];
          ufill++;
        end
      end else if (tag == L_UMIN) begin
        rflags[0] = 1'b1; rlo = val[15:0];
      end else if (tag == L_UMAX) begin
        rflags[1] = 1'b1; rhi = val[15:0];
      end
    end
  endfunction

  // one descriptor byte in, expected records out
  function automatic void take_byte(logic [7:0] b, logic last);
    int n0, ds, idx;
    logic [1:0] v;
    n0 = expected_recs.size();
    case (phase)
      PH_IDLE: begin
        if (b == LONG_PREFIX) begin
          phase = PH_LHDR; pend = 2;
        end else begin
          ds = (b[1:0] == 2'd3) ? 4 : b[1:0];
          prefix = b;
          accum = 0;
          if (ds == 0) run_short_item(b, 32'h0);
          else begin
            phase = PH_SHORT; pend = ds;
          end
        end
      end
      PH_SHORT: begin
        ds = (prefix[1:0] == 2'd3) ? 4 : prefix[1:0];
        idx = (ds - pend) & 3;
        accum = accum | (32'(b) << (8 * idx));
        pend--;
        if (pend == 0) begin
          phase = PH_IDLE;
          run_short_item(prefix, accum);
        end
      end
      PH_LHDR: begin
        if (pend == 2) begin
          accum = 32'(b); pend = 1;
        end else if (accum == 0) begin
          phase = PH_IDLE; pend = 0;
        end else begin
          phase = PH_LDATA; pend = accum[7:0];
        end
      end
      default: begin
        pend--;
        if (pend == 0) phase = PH_IDLE;
      end
    endcase
    if (last) begin
      if (phase != PH_IDLE) v = VER_TRUNC;
      else if (!pad_seen) v = VER_NO_PAD;
      else if (nemit == 0) v = VER_NO_FIELDS;
      else v = VER_OK;
      add_rec(REC_VERDICT, 8'h0, 16'h0, 8'h0, top_pg, top_us, 32'h0, 32'h0, ids_used, v);
      clear_parser();
    end
    if (expected_recs.size() > n0) expected_recs[expected_recs.size()-1].last = 1'b1;
  endfunction

  function automatic void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // watch the request, result and register ports
  always @(posedge clk) begin
    field_rec_t e;
    if (rst) begin
      force_pad = 1'b0;
      clear_parser();
      expected_recs.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_FORCE_ADDR)
        force_pad = pwdata[0];
      if (din.valid && din.ready) take_byte(din.desc_byte, din.end_of_descriptor);
      if (dout.valid && dout.ready) begin
        if (expected_recs.size() == 0) begin
          $error("record with no expectation waiting");
          errors++;
        end else begin
          e = expected_recs.pop_front();
          cmp("record_kind", e.kind, dout.record_kind);
          cmp("report_id", e.id, dout.report_id);
          cmp("bit_offset", e.off, dout.bit_offset);
          cmp("bit_size", e.bsize, dout.bit_size);
          cmp("usage_page", e.page, dout.usage_page);
          cmp("usage_id", e.usage, dout.usage_id);
          cmp("logical_min", e.lmin, dout.logical_min);
          cmp("logical_max", e.lmax, dout.logical_max);
          cmp("uses_report_ids", e.ids, dout.uses_report_ids);
          cmp("verdict", e.ver, dout.verdict);
          cmp("last_of_run", e.last, dout.last_of_run);
        end
      end
    end
    outstanding = expected_recs.size();
  end

endmodule

FILE: bench/hid_descriptor_field_extractor_test.sv
`timescale 1ns / 100ps

module hid_descriptor_field_extractor_test;
  import hdfe_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_BYTES = 160;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  int errors, outstanding;
  int bytes_sent;
  int idle_cycles;
  int burst_left;
  bit no_gaps;
  bit long_done;
  int long_left, run_left, rmode;
  logic [8:0] desc_q[$];

  hdfe_in_if din();
  hdfe_out_if dout();

  hid_descriptor_field_extractor dut (
    .clk(clk), .rst(rst), .desc_in(din), .rec_out(dout),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  hdfe_record_checker checker_i (
    .clk(clk), .rst(rst), .din(din), .dout(dout),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on requests and records
  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("hid_descriptor_field_extractor verification failed");
      $finish;
    end
  end

  // record receiver with its own stall pattern and one long hold-off
  initial begin
    dout.ready = 1'b0;
    long_done = 0; long_left = 0; run_left = 0; rmode = 0;
    forever begin
      @(negedge clk);
      if (long_left > 0) begin
        long_left--;
        dout.ready <= 1'b0;
      end else if (!long_done && bytes_sent >= 150) begin
        long_done = 1;
        long_left = 400;
        dout.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(4, 40);
          rmode = $urandom_range(0, 3);
        end
        run_left--;
        case (rmode)
          0: dout.ready <= 1'b1;
          1: dout.ready <= 1'($urandom_range(0, 1));
          2: dout.ready <= ($urandom_range(0, 3) != 0);
          default: dout.ready <= ~dout.ready;
        endcase
      end
    end
  end

  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // let the block drain fully before touching the register
  task automatic set_force(logic val);
    @(negedge clk);
    din.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    reg_write(REG_FORCE_ADDR, {31'b0, val});
  endtask

  task automatic send_byte(logic [8:0] entry);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      @(negedge clk);
      din.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    din.valid <= 1'b1;
    din.desc_byte <= entry[7:0];
    din.end_of_descriptor <= entry[8];
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_descriptor();
    desc_q[desc_q.size()-1][8] = 1'b1;
    foreach (desc_q[i]) send_byte(desc_q[i]);
    desc_q.delete();
  endtask

  function automatic void add_bytes(logic [7:0] b[]);
    foreach (b[i]) desc_q.push_back({1'b0, b[i]});
  endfunction

  function automatic void add_item(logic [1:0] itype, logic [3:0] tag, logic [31:0] v,
                                   int nbytes);
    logic [1:0] sc;
    sc = (nbytes == 4) ? 2'd3 : nbytes[1:0];
    desc_q.push_back({1'b0, tag, itype, sc});
    for (int i = 0; i < nbytes; i++) desc_q.push_back({1'b0, v[8*i +: 8]});
  endfunction

  function automatic void add_rand_item(logic [1:0] itype, logic [3:0] tag);
    int nb;
    logic [31:0] v;
    nb = $urandom_range(0, 3);
    if (nb == 3) nb = 4;
    v = $urandom;
    add_item(itype, tag, v, nb);
  endfunction

  function automatic void add_size_item(logic [1:0] itype, logic [3:0] tag, logic [31:0] v);
    add_item(itype, tag, v, (v > 32'hFFFF) ? 4 : (v > 32'hFF) ? 2 : 1);
  endfunction

  // pad descriptor with random content, now and then with a broken tail
  function automatic void build_pad_descriptor();
    int groups, nu, sz, cnt;
    logic [15:0] top_u;
    case ($urandom_range(0, 2))
      0: top_u = USAGE_JOY;
      1: top_u = USAGE_PAD;
      default: top_u = USAGE_MULTI;
    endcase
    add_item(ITYPE_GLOBAL, G_PAGE, PAGE_GDESK, 1);
    add_item(ITYPE_LOCAL, L_USAGE, top_u, 1);
    add_item(ITYPE_MAIN, TAG_COLL, 32'h1, 1);
    groups = $urandom_range(1, 4);
    for (int g = 0; g < groups; g++) begin
      if ($urandom_range(0, 2) == 0) add_size_item(ITYPE_GLOBAL, G_RID, $urandom_range(0, 255));
      if ($urandom_range(0, 1)) add_rand_item(ITYPE_GLOBAL, G_PAGE);
      add_rand_item(ITYPE_GLOBAL, G_LMIN);
      add_rand_item(ITYPE_GLOBAL, G_LMAX);
      case ($urandom_range(0, 9))
        0: sz = 32;
        1: sz = 0;
        2: sz = $urandom_range(33, 255);
        default: sz = $urandom_range(1, 16);
      endcase
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 5);
      add_size_item(ITYPE_GLOBAL, G_RSIZE, sz);
      add_size_item(ITYPE_GLOBAL, G_RCOUNT, cnt);
      nu = $urandom_range(0, 3);
      for (int i = 0; i < nu; i++) add_rand_item(ITYPE_LOCAL, L_USAGE);
      if ($urandom_range(0, 2) == 0) begin
        add_rand_item(ITYPE_LOCAL, L_UMIN);
        add_rand_item(ITYPE_LOCAL, L_UMAX);
      end
      if ($urandom_range(0, 3) == 0) add_item(ITYPE_GLOBAL, G_PUSH, 0, 0);
      if ($urandom_range(0, 5) == 0) add_bytes('{LONG_PREFIX, 8'h02, 8'h10, 8'hA5, 8'h5A});
      if ($urandom_range(0, 4) == 0) add_item(ITYPE_MAIN, TAG_COLL, 32'h0, 1);
      add_item(ITYPE_MAIN, TAG_INPUT,
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : 32'h2, 1);
      if ($urandom_range(0, 3) == 0) add_item(ITYPE_GLOBAL, G_POP, 0, 0);
      if ($urandom_range(0, 4) == 0) add_item(ITYPE_MAIN, TAG_END_COLL, 0, 0);
    end
    add_item(ITYPE_MAIN, TAG_END_COLL, 0, 0);
    if ($urandom_range(0, 3) == 0) add_item(ITYPE_MAIN, TAG_END_COLL, 0, 0);
    // broken tail now and then
    if ($urandom_range(0, 9) == 0) desc_q.push_back({1'b0, 8'h27});
  endfunction

  initial begin
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    din.valid = 1'b0; din.desc_byte = 8'h0; din.end_of_descriptor = 1'b0;
    bytes_sent = 0; burst_left = 0; no_gaps = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    reg_write(REG_FORCE_ADDR, 32'h0);

    // empty and truncated descriptors
    add_bytes('{8'h00});
    send_descriptor();
    add_bytes('{8'h05});
    send_descriptor();

    // pad with long items, sign cases, full stack, odd sizes, constant input
    add_bytes('{8'h05, 8'h01, 8'h09, 8'h05, 8'hA1, 8'h01,
                LONG_PREFIX, 8'h02, 8'h10, 8'hAA, 8'hBB, LONG_PREFIX, 8'h00, 8'h10,
                8'h85, 8'h03, 8'h15, 8'h80, 8'h26, 8'hFF, 8'h7F, 8'h75, 8'h08,
                8'h95, 8'h03, 8'h09, 8'h30, 8'h19, 8'h40, 8'h29, 8'h41, 8'h81, 8'h02,
                8'h17, 8'h00, 8'h00, 8'h00, 8'h80, 8'h27, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h75, 8'h20, 8'h95, 8'h01, 8'h81, 8'h02,
                8'hA4, 8'hA4, 8'hA4, 8'hA4, 8'hA4, 8'h75, 8'h00, 8'h81, 8'h02,
                8'h75, 8'h21, 8'h81, 8'h02, 8'hB4, 8'hB4, 8'hB4, 8'hB4, 8'hB4,
                8'h81, 8'h01, 8'h81, 8'h03, 8'hC0, 8'hC0});
    send_descriptor();

    // usage list overflow and field limit
    add_bytes('{8'h05, 8'h01, 8'h09, 8'h04, 8'hA1, 8'h01});
    for (int i = 0; i < 34; i++) add_bytes('{8'h09, 8'(i + 1)});
    add_bytes('{8'h75, 8'h01, 8'h95, 8'h24, 8'h81, 8'h02, 8'hC0});
    send_descriptor();

    // forced pad on a zero page and usage
    set_force(1'b1);
    add_bytes('{8'hA1, 8'h01, 8'h75, 8'h04, 8'h95, 8'h02, 8'h81, 8'h02, 8'hC0});
    send_descriptor();
    set_force(1'b0);

    // random descriptors with force phases
    for (int d = 0; bytes_sent < 160 + RANDOM_BYTES; d++) begin
      no_gaps = (d % 5 == 0);
      if (d == 2) set_force(1'b1);
      if (d == 4) set_force(1'b0);
      if ($urandom_range(0, 5) == 0) begin
        for (int i = $urandom_range(1, 12); i > 0; i--)
          desc_q.push_back({1'b0, 8'($urandom)});
      end else begin
        build_pad_descriptor();
      end
      send_descriptor();
    end

    @(negedge clk);
    din.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("hid_descriptor_field_extractor verification clean");
    else $display("hid_descriptor_field_extractor verification failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/hdfe_pkg.sv
hdl/hdfe_if.sv
hdl/hdfe_ram.sv
hdl/hdfe_ctrl.sv
hdl/hdfe_dp.sv
hdl/hid_descriptor_field_extractor.sv
bench/hdfe_record_checker.sv
bench/hid_descriptor_field_extractor_test.sv
